// ===== hdl/pres_pkg.sv =====
// ----------------------------------------------------------------------------
// pres_pkg: shared types, constants and layer functions
// s-box tables, bit permutation layers, control structs and fsm states
// ----------------------------------------------------------------------------
package pres_pkg;

    localparam int ROUND_KEYS = 32;
    localparam int RND_W      = $clog2(ROUND_KEYS);
    localparam int BLK_W      = 64;
    localparam int CFG_IDX_W  = 2;

    typedef logic [RND_W-1:0] t_rnd;
    typedef logic [BLK_W-1:0] t_blk;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 2'd2;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    localparam logic [3:0] FWD_SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] INV_SBOX [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_READ,
        ST_LAST,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_XOR,
        DP_ENC,
        DP_DEC
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctrl;

    typedef struct packed {
        logic load;
        logic step;
        t_rnd rc;
    } t_ks_ctrl;

    function automatic t_blk sub_layer(input t_blk x, input logic inv);
        t_blk r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = inv ? INV_SBOX[x[4*n +: 4]] : FWD_SBOX[x[4*n +: 4]];
        end
        return r;
    endfunction

    // bit i moves to (mul * i) mod 63, bit 63 stays
    function automatic t_blk perm_layer(input t_blk x, input int mul);
        t_blk r;
        for (int i = 0; i < BLK_W - 1; i++) begin
            r[(i * mul) % (BLK_W - 1)] = x[i];
        end
        r[BLK_W-1] = x[BLK_W-1];
        return r;
    endfunction

endpackage

// ===== hdl/present_block_cipher.sv =====
// ----------------------------------------------------------------------------
// present_block_cipher: present cipher with 80 or 128-bit key
// round keys are expanded into a memory, then read back in round order
// ----------------------------------------------------------------------------
// operation: 32 round keys are expanded into the round key memory, then read
//   back in 32 memory reads with registered read data, then the output
//   register is loaded, waiting while a valid output word is stalled; the
//   block then returns to idle and only there takes the next word
// reset: synchronous, active low; key registers, key size and control clear
//   to zero, the round key memory is not cleared
// ----------------------------------------------------------------------------
module present_block_cipher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pres_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  pres_pkg::t_blk                 i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  pres_pkg::t_blk                 i_block_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pres_pkg::t_blk                 o_block_out
);
    import pres_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_rnd     r_cnt;
    t_rnd     n_cnt;
    logic     r_action;
    logic     r_rd_vld;
    logic     n_rd_vld;
    t_rnd     r_rd_addr;
    t_rnd     w_raddr;
    t_blk     r_key_high;
    t_blk     r_key_low;
    logic     r_key_size;
    logic     r_out_valid;
    t_blk     r_out_data;
    logic     w_in_acc;
    logic     w_out_load;
    logic     w_we;
    t_ks_ctrl w_ks;
    t_dp_ctrl w_dp;
    t_blk     w_round_key;
    t_blk     w_rdata;
    t_blk     w_state;

    assign w_in_acc = i_in_valid && (r_state == ST_IDLE);
    assign w_raddr  = (r_action == ACT_DECRYPT) ? t_rnd'(ROUND_KEYS - 1) - r_cnt : r_cnt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_key_size <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_SIZE: r_key_size <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_rd_vld   = 1'b0;
        w_we       = 1'b0;
        w_out_load = 1'b0;
        w_ks.load  = 1'b0;
        w_ks.step  = 1'b0;
        w_ks.rc    = r_cnt + t_rnd'(1);
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_ks.load = 1'b1;
                    n_cnt     = '0;
                    n_state   = ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                w_we      = 1'b1;
                w_ks.step = 1'b1;
                n_cnt     = r_cnt + t_rnd'(1);
                if (r_cnt == t_rnd'(ROUND_KEYS - 1)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_rd_vld = 1'b1;
                n_cnt    = r_cnt + t_rnd'(1);
                if (r_cnt == t_rnd'(ROUND_KEYS - 1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // round key 0 is a plain key add, in either direction
        if (w_in_acc) begin
            w_dp.op = DP_LOAD;
        end else if (r_rd_vld) begin
            if (r_rd_addr == '0) begin
                w_dp.op = DP_XOR;
            end else if (r_action == ACT_DECRYPT) begin
                w_dp.op = DP_DEC;
            end else begin
                w_dp.op = DP_ENC;
            end
        end else begin
            w_dp.op = DP_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_action    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_rd_addr <= w_raddr;
            if (w_in_acc) begin
                r_action <= i_action;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_state;
        end
    end

    pres_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ks),
        .i_key_high  (r_key_high),
        .i_key_low   (r_key_low),
        .i_key_size  (r_key_size),
        .o_round_key (w_round_key)
    );

    pres_rk_mem u_rk_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt),
        .i_wdata (w_round_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pres_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_dp),
        .i_block     (i_block_in),
        .i_round_key (w_rdata),
        .o_state     (w_state)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_block_out = r_out_data;

endmodule

// ===== hdl/pres_rk_mem.sv =====
// ----------------------------------------------------------------------------
// pres_rk_mem: round key memory
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pres_rk_mem (
    input  logic          i_clk,
    input  logic          i_we,
    input  pres_pkg::t_rnd i_waddr,
    input  pres_pkg::t_blk i_wdata,
    input  pres_pkg::t_rnd i_raddr,
    output pres_pkg::t_blk o_rdata
);
    import pres_pkg::*;

    t_blk r_mem [ROUND_KEYS];
    t_blk r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pres_key_sched.sv =====
// ----------------------------------------------------------------------------
// pres_key_sched: working key register and schedule step
// 80-bit and 128-bit present key update, while stepping one round key per cycle
// ----------------------------------------------------------------------------
module pres_key_sched (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pres_pkg::t_ks_ctrl i_ctrl,
    input  pres_pkg::t_blk     i_key_high,
    input  pres_pkg::t_blk     i_key_low,
    input  logic               i_key_size,
    output pres_pkg::t_blk     o_round_key
);
    import pres_pkg::*;

    t_blk         r_hi;
    t_blk         r_lo;
    t_blk         n_hi;
    t_blk         n_lo;
    logic [127:0] w_k128;
    logic [79:0]  w_k80;

    always_comb begin
        w_k128 = '0;
        w_k80  = '0;
        n_hi   = r_hi;
        n_lo   = r_lo;
        if (i_ctrl.load) begin
            n_hi = i_key_high;
            n_lo = i_key_size ? i_key_low : {48'd0, i_key_low[63:48]};
        end else if (i_ctrl.step) begin
            if (i_key_size) begin
                // rotate left by 61 over 128 bits
                w_k128 = {r_hi, r_lo};
                w_k128 = {w_k128[66:0], w_k128[127:67]};
                w_k128[127:124] = FWD_SBOX[w_k128[127:124]];
                w_k128[123:120] = FWD_SBOX[w_k128[123:120]];
                w_k128[66:62]   = w_k128[66:62] ^ i_ctrl.rc;
                n_hi = w_k128[127:64];
                n_lo = w_k128[63:0];
            end else begin
                // rotate left by 61 over 80 bits
                w_k80 = {r_hi, r_lo[15:0]};
                w_k80 = {w_k80[18:0], w_k80[79:19]};
                w_k80[79:76] = FWD_SBOX[w_k80[79:76]];
                w_k80[19:15] = w_k80[19:15] ^ i_ctrl.rc;
                n_hi = w_k80[79:16];
                n_lo = {48'd0, w_k80[15:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_round_key = r_hi;

endmodule

// ===== hdl/pres_datapath.sv =====
// ----------------------------------------------------------------------------
// pres_datapath: cipher state register and round logic
// key add, forward round and inverse round on the 64-bit state
// ----------------------------------------------------------------------------
module pres_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pres_pkg::t_dp_ctrl i_ctrl,
    input  pres_pkg::t_blk     i_block,
    input  pres_pkg::t_blk     i_round_key,
    output pres_pkg::t_blk     o_state
);
    import pres_pkg::*;

    t_blk r_s;
    t_blk n_s;

    always_comb begin
        case (i_ctrl.op)
            DP_HOLD: n_s = r_s;
            DP_LOAD: n_s = i_block;
            DP_XOR:  n_s = r_s ^ i_round_key;
            DP_ENC:  n_s = perm_layer(sub_layer(r_s, 1'b0), 16) ^ i_round_key;
            DP_DEC:  n_s = sub_layer(perm_layer(r_s ^ i_round_key, 4), 1'b1);
            default: n_s = r_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    assign o_state = r_s;

endmodule

// ===== test/present_block_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// present_block_cipher_tb: self-checking bench for the present cipher
// drives encrypt and decrypt words under a series of 80 and 128-bit keys,
// predicts every result with an independent model of the key schedule and
// round layers, and compares each output word in arrival order
// ----------------------------------------------------------------------------
module present_block_cipher_tb;

    import pres_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AT     = 300;
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 900;
    localparam int RAND_PHASES = 10;
    localparam int RAND_WORDS  = 143;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [3:0] SBOX_F [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] SBOX_R [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    typedef struct packed {
        logic act;
        t_blk blk;
    } t_cipher_word;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    t_blk                 i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_action    = 1'b0;
    t_blk                 i_block_in  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_blk                 o_block_out;

    // mirror of the key registers as seen by the block
    t_blk key_hi_cfg   = '0;
    t_blk key_lo_cfg   = '0;
    logic key_wide_cfg = 1'b0;

    t_cipher_word pending_words [$];
    t_blk         expected_blocks [$];

    int   words_queued = 0;
    int   words_in     = 0;
    int   words_out    = 0;
    int   err_cnt      = 0;
    int   n_enc        = 0;
    int   n_dec        = 0;
    int   n_wide       = 0;
    int   n_settings   = 1;
    int   cycles       = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;
    logic in_fire      = 1'b0;

    wire calm = (words_in >= CALM_FROM) && (words_in < CALM_TO);

    present_block_cipher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_block_in  (i_block_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_block_out (o_block_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_blk nib_sub(input t_blk x, input logic inv);
        t_blk y;
        for (int n = 0; n < 16; n++) begin
            y[4*n +: 4] = inv ? SBOX_R[x[4*n +: 4]] : SBOX_F[x[4*n +: 4]];
        end
        return y;
    endfunction

    // bit i lands on (mul * i) mod 63, the top bit stays put
    function automatic t_blk bit_shuffle(input t_blk x, input int mul);
        t_blk y;
        y[63] = x[63];
        for (int i = 0; i < 63; i++) begin
            y[(i * mul) % 63] = x[i];
        end
        return y;
    endfunction

    function automatic t_blk present_crypt(input t_blk khi, input t_blk klo,
                                           input logic wide, input logic act,
                                           input t_blk din);
        t_blk         rk [ROUND_KEYS];
        logic [79:0]  k80;
        logic [127:0] k128;
        t_blk         s;
        int           r;
        k80   = {khi, klo[63:48]};
        k128  = {khi, klo};
        rk[0] = khi;
        for (r = 1; r < ROUND_KEYS; r++) begin
            if (wide) begin
                k128 = {k128[66:0], k128[127:67]};
                k128[127:124] = SBOX_F[k128[127:124]];
                k128[123:120] = SBOX_F[k128[123:120]];
                k128[66:62] = k128[66:62] ^ 5'(r);
                rk[r] = k128[127:64];
            end else begin
                k80 = {k80[18:0], k80[79:19]};
                k80[79:76] = SBOX_F[k80[79:76]];
                k80[19:15] = k80[19:15] ^ 5'(r);
                rk[r] = k80[79:16];
            end
        end
        s = din;
        if (act == ACT_ENCRYPT) begin
            s = s ^ rk[0];
            for (r = 1; r < ROUND_KEYS; r++) begin
                s = bit_shuffle(nib_sub(s, 1'b0), 16) ^ rk[r];
            end
        end else begin
            for (r = ROUND_KEYS - 1; r > 0; r--) begin
                s = nib_sub(bit_shuffle(s ^ rk[r], 4), 1'b1);
            end
            s = s ^ rk[0];
        end
        return s;
    endfunction

    function automatic t_blk pick_block();
        t_blk b;
        int   k;
        k = $urandom_range(99);
        b = {$urandom, $urandom};
        if (k < 8) begin
            b = '0;
        end else if (k < 16) begin
            b = '1;
        end else if (k < 24) begin
            b = t_blk'(1) << $urandom_range(63);
        end else if (k < 32) begin
            b = ~(t_blk'(1) << $urandom_range(63));
        end
        return b;
    endfunction

    task automatic add_word(input logic act, input t_blk blk);
        pending_words.push_back('{act: act, blk: blk});
        words_queued++;
    endtask

    task automatic add_extreme_words();
        add_word(ACT_ENCRYPT, '0);
        add_word(ACT_ENCRYPT, '1);
        add_word(ACT_DECRYPT, '0);
        add_word(ACT_DECRYPT, '1);
    endtask

    // random words, some extremes, some followed by the opposite action on their result
    task automatic add_random_words(input int n);
        int   added;
        logic act;
        t_blk blk;
        added = 0;
        while (added < n) begin
            act = $urandom_range(1);
            blk = pick_block();
            add_word(act, blk);
            added++;
            if ($urandom_range(99) < 30) begin
                add_word(~act, present_crypt(key_hi_cfg, key_lo_cfg, key_wide_cfg,
                                             act, blk));
                added++;
            end
        end
    endtask

    task automatic wait_results();
        while (words_out != words_queued) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_blk val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            CFG_KEY_HIGH: key_hi_cfg = val;
            CFG_KEY_LOW:  key_lo_cfg = val;
            CFG_KEY_SIZE: key_wide_cfg = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // sender: new word only once the previous one has gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
                i_in_valid <= 1'b1;
                i_action   <= pending_words[0].act;
                i_block_in <= pending_words[0].blk;
                pending_words.delete(0);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold so the block backs up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 25);
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            expected_blocks.push_back(present_crypt(key_hi_cfg, key_lo_cfg, key_wide_cfg,
                                                    i_action, i_block_in));
            words_in++;
            if (i_action == ACT_ENCRYPT) n_enc++;
            else n_dec++;
            if (key_wide_cfg) n_wide++;
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            words_out++;
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected block_out word, expected none, got %h",
                         $time, o_block_out);
                err_cnt++;
            end else if (o_block_out !== expected_blocks[0]) begin
                $display("%0t: block_out mismatch, expected %h, got %h",
                         $time, expected_blocks[0], o_block_out);
                err_cnt++;
                expected_blocks.delete(0);
            end else begin
                expected_blocks.delete(0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time,
                     expected_blocks.size());
            $display("present_block_cipher_tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_blk hi_pick;
        t_blk lo_pick;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero key, 80-bit mode straight out of reset
        add_extreme_words();
        add_word(ACT_ENCRYPT, 64'h8000_0000_0000_0001);
        add_word(ACT_DECRYPT, 64'h0123_4567_89AB_CDEF);
        add_word(ACT_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
        add_word(ACT_DECRYPT, 64'h5555_5555_5555_5555);
        wait_results();

        // all-ones 80-bit key
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LOW, '1);
        n_settings++;
        add_extreme_words();
        wait_results();

        // all-ones 128-bit key, size written with every bit set
        write_reg(CFG_KEY_SIZE, '1);
        n_settings++;
        add_extreme_words();
        wait_results();

        // zero 128-bit key
        write_reg(CFG_KEY_HIGH, '0);
        write_reg(CFG_KEY_LOW, '0);
        n_settings++;
        add_extreme_words();
        wait_results();

        // back to 80-bit through a value whose low bit is clear, plus a
        // write to the unused index that must leave the key alone
        write_reg(CFG_KEY_SIZE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(CFG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_LOW, 64'hFEDC_0000_0000_0000);
        write_reg(CFG_SPARE, '1);
        n_settings++;
        add_word(ACT_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        add_word(ACT_DECRYPT, 64'hFEDC_BA98_7654_3210);
        wait_results();
        // bits below the 80-bit key must not matter
        write_reg(CFG_KEY_LOW, 64'hFEDC_FFFF_FFFF_FFFF);
        add_word(ACT_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        add_word(ACT_DECRYPT, 64'hFEDC_BA98_7654_3210);
        wait_results();

        for (int p = 0; p < RAND_PHASES; p++) begin
            hi_pick = pick_block();
            lo_pick = pick_block();
            write_reg(CFG_KEY_HIGH, hi_pick);
            write_reg(CFG_KEY_LOW, lo_pick);
            write_reg(CFG_KEY_SIZE, {{63{1'b0}}, p[0]} | ({$urandom, $urandom} << 1));
            if ($urandom_range(3) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
            n_settings++;
            add_random_words(RAND_WORDS);
            wait_results();
        end

        repeat (80) @(posedge i_clk);
        if (expected_blocks.size() != 0) begin
            $display("%0t: %0d expected block_out words never arrived", $time,
                     expected_blocks.size());
            err_cnt++;
        end
        $display("ran %0d words (%0d encrypt, %0d decrypt) across %0d key settings,",
                 words_in, n_enc, n_dec, n_settings);
        $display("%0d of them under 128-bit keys; %0d errors", n_wide, err_cnt);
        if (err_cnt == 0) begin
            $display("present_block_cipher_tb OK");
        end else begin
            $display("present_block_cipher_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pres_pkg.sv
hdl/pres_rk_mem.sv
hdl/pres_key_sched.sv
hdl/pres_datapath.sv
hdl/present_block_cipher.sv
test/present_block_cipher_tb.sv
